// ----- design/rdiv_pkg.sv -----
// Package for the restoring unsigned divider.
// Holds the operand width, payload structs, cell control struct and FSM states.
// No dependencies.
`default_nettype none

package rdiv_pkg;

    // Operand width used by the datapath (2..32)
    localparam int WIDTH   = 16;
    // Width of the payload fields
    localparam int FIELD_W = 16;
    // Zero-extended width used to pick the low WIDTH bits of a field
    localparam int EXT_W   = WIDTH + FIELD_W;
    // Round counter width
    localparam int CNT_W   = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef struct packed {
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
    } rsp_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic load;  // capture new operands
        logic step;  // perform one shift-subtract round
        logic neg;   // trial difference is negative: keep the shifted value
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } state_t;

endpackage

`default_nettype wire

// ----- design/rdiv_cell.sv -----
// One bit slice of the restoring divider: accumulator, quotient and divisor bit.
// Ripples the trial-subtract borrow to its upper neighbor.
// Depends on rdiv_pkg.
`default_nettype none

module rdiv_cell (
    input  wire                     clk,
    input  rdiv_pkg::cell_ctrl_t    ctrl,
    input  wire                     dvd_bit,
    input  wire                     dvs_bit,
    input  wire                     acc_in,
    input  wire                     q_in,
    input  wire                     borrow_in,
    output logic                    acc_bit,
    output logic                    q_bit,
    output logic                    dvs_out,
    output logic                    borrow_out
);
    import rdiv_pkg::*;

    logic acc_reg, acc_next;
    logic q_reg, q_next;
    logic m_reg, m_next;
    logic diff;

    // Full subtractor on the shifted-in accumulator bit
    always_comb
    begin
        diff       = acc_in ^ m_reg ^ borrow_in;
        borrow_out = (~acc_in & (m_reg | borrow_in)) | (m_reg & borrow_in);
    end

    // Next state: load operands, or shift and keep either difference or shifted bit
    always_comb
    begin
        acc_next = acc_reg;
        q_next   = q_reg;
        m_next   = m_reg;
        if (ctrl.load)
        begin
            acc_next = 1'b0;
            q_next   = dvd_bit;
            m_next   = dvs_bit;
        end
        else if (ctrl.step)
        begin
            acc_next = ctrl.neg ? acc_in : diff;
            q_next   = q_in;
        end
    end

    // Datapath bits, no reset needed
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        q_reg   <= q_next;
        m_reg   <= m_next;
    end

    assign acc_bit = acc_reg;
    assign q_bit   = q_reg;
    assign dvs_out = m_reg;

endmodule

`default_nettype wire

// ----- design/restoring_unsigned_divider_unit.sv -----
// Top level of the restoring unsigned divider: sequencer, output register and
// the row of rdiv_cell bit slices.
// Depends on rdiv_pkg and rdiv_cell.
//
// Usage:
//   Request channel req_valid / req_stall / req_data carries dividend and
//   divisor; a transaction completes on a clock edge with req_valid high and
//   req_stall low. Response channel rsp_valid / rsp_stall / rsp_data returns
//   quotient and remainder, one response per request, in order.
//   Sequence: the operands load into the cell row at the accept edge, then
//   WIDTH rounds (one per clock, one shift-subtract-restore per round) run
//   through the row, and the result waits in the cells in S_HOLD until it
//   moves to the output register, which raises the response valid.
//   The single row of cells serves one division at a time, so no new
//   request is taken until the last result leaves the cells. The next
//   request is taken on the same edge the finished result goes to the output
//   register.
//   A zero divisor returns an all-ones quotient and the dividend as remainder.
//   Reset clears the sequencer and the response valid. While the receiver
//   stalls, the response holds; a finished result waits in the cells and
//   req_stall stays high until the output register frees up.
`default_nettype none

module restoring_unsigned_divider_unit (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             req_valid,
    output logic            req_stall,
    input  rdiv_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  wire             rsp_stall,
    output rdiv_pkg::rsp_t  rsp_data
);
    import rdiv_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_data_reg;

    cell_ctrl_t        ctrl;
    logic              accept;
    logic              out_free;
    logic              xfer;

    logic [EXT_W-1:0]  dvd_ext;
    logic [EXT_W-1:0]  dvs_ext;
    logic [WIDTH-1:0]  dvd_w;
    logic [WIDTH-1:0]  dvs_w;
    logic [WIDTH-1:0]  acc_w;
    logic [WIDTH-1:0]  q_w;
    logic [WIDTH-1:0]  m_w;
    logic [WIDTH-1:0]  borrow_w;

    // Operand bits used by the datapath
    assign dvd_ext = EXT_W'(req_data.dividend);
    assign dvs_ext = EXT_W'(req_data.divisor);
    assign dvd_w   = dvd_ext[WIDTH-1:0];
    assign dvs_w   = dvs_ext[WIDTH-1:0];

    // Handshake
    assign out_free  = ~rsp_valid_reg | ~rsp_stall;
    assign xfer      = (state_reg == S_HOLD) && out_free;
    assign req_stall = ~((state_reg == S_IDLE) || xfer);
    assign accept    = req_valid & ~req_stall;

    // Cell control; negative when the full-width trial subtract borrows
    assign ctrl.load = accept;
    assign ctrl.step = (state_reg == S_RUN);
    assign ctrl.neg  = ~acc_w[WIDTH-1] & borrow_w[WIDTH-1];

    // Row of bit slices; cell 0 takes the quotient MSB into the accumulator
    genvar i;
    generate
        for (i = 0; i < WIDTH; i++)
        begin : g_cell
            logic acc_in_i, q_in_i, borrow_in_i;
            if (i == 0)
            begin : g_lsb
                assign acc_in_i    = q_w[WIDTH-1];
                assign q_in_i      = ~ctrl.neg;
                assign borrow_in_i = 1'b0;
            end
            else
            begin : g_mid
                assign acc_in_i    = acc_w[i-1];
                assign q_in_i      = q_w[i-1];
                assign borrow_in_i = borrow_w[i-1];
            end

            rdiv_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .dvd_bit    (dvd_w[i]),
                .dvs_bit    (dvs_w[i]),
                .acc_in     (acc_in_i),
                .q_in       (q_in_i),
                .borrow_in  (borrow_in_i),
                .acc_bit    (acc_w[i]),
                .q_bit      (q_w[i]),
                .dvs_out    (m_w[i]),
                .borrow_out (borrow_w[i])
            );
        end
    endgenerate

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    cnt_next   = '0;
                end
            end
            S_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (xfer)
                begin
                    rsp_valid_next = 1'b1;
                    if (accept)
                    begin
                        state_next = S_RUN;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            rsp_data_reg.quotient  <= FIELD_W'(q_w);
            rsp_data_reg.remainder <= FIELD_W'(acc_w);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef SYNTHESIS
    // An accepted request always starts the rounds
    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_RUN) && (cnt_reg == '0))
        else $error("accepted request did not start the rounds");

    // The last round leads to the hold state
    a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) && (cnt_reg == CNT_W'(WIDTH - 1)) |=> (state_reg == S_HOLD))
        else $error("rounds did not finish after WIDTH steps");

    // A finished result always reaches the output register
    a_xfer_valid: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |=> rsp_valid_reg)
        else $error("result transfer did not raise response valid");

    // Remainder stays below a nonzero divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && (m_w != '0)) |-> (acc_w < m_w))
        else $error("remainder not below divisor");

    // No request taken while rounds are running
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> req_stall)
        else $error("request channel open during rounds");
`endif

endmodule

`default_nettype wire
